// File: hw/rtl/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter.
// Included by the top level; depends on nothing else.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV2RGB_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSV2RGB_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsv2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 17;
  localparam int HUE_W     = 17;
  localparam int PROD_W    = 2 * FIELD_W;

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(longint'(1) << FRAC_BITS);

  // Hue is in 1/256 degree units: a full turn is 360*256, a sector 60*256.
  localparam logic [HUE_W-1:0] HUE_FULL_TURN = HUE_W'(360 * 256);
  localparam logic [HUE_W-1:0] HUE_SECTOR    = HUE_W'(60 * 256);

  localparam int NUM_SECTORS = 6;
  localparam int SECTOR_W    = 3;
  localparam int REM_W       = $clog2(60 * 256);

  // Sector codes, named after the hue range each one covers.
  localparam logic [SECTOR_W-1:0] SEC_R_TO_Y = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_Y_TO_G = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_G_TO_C = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_C_TO_B = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_B_TO_M = 3'd4;
  localparam logic [SECTOR_W-1:0] SEC_M_TO_R = 3'd5;

  // The fraction f = (rem << FRAC_BITS) / HUE_SECTOR is computed as
  // (rem * F_MUL) >> F_SHIFT with a rounded-up reciprocal, which is exact
  // over the whole remainder range.
  localparam int     F_SHIFT = 18;
  localparam longint F_MUL_L = ((longint'(1) << (F_SHIFT + FRAC_BITS)) + (60 * 256) - 1)
                               / (60 * 256);
  localparam int     F_MUL_W = $clog2(F_MUL_L + 1);
  localparam logic [F_MUL_W-1:0] F_MUL = F_MUL_W'(F_MUL_L);
  localparam int     F_PROD_W = REM_W + F_MUL_W;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [REM_W-1:0]    rem;
  } hue_split_t;

endpackage

`default_nettype wire

// File: hw/rtl/hsv2rgb_hue_split.sv
// Hue decode: folds hues of a full turn or more to zero, then splits the
// hue into a sector number and the remainder inside it. Uses hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_hue_split
  import hsv2rgb_pkg::*;
(
  input  wire logic [HUE_W-1:0] hue,
  output hue_split_t            split
);

  logic [HUE_W-1:0]    hue_fold;
  logic [SECTOR_W-1:0] sector;
  logic [HUE_W-1:0]    base;
  logic [HUE_W-1:0]    rem_full;

  assign hue_fold = (hue >= HUE_FULL_TURN) ? '0 : hue;

  // Each boundary is tested independently; the highest one passed wins.
  always_comb begin
    sector = SEC_R_TO_Y;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue_fold >= HUE_W'(k * (60 * 256))) begin
        sector = SECTOR_W'(k);
      end
    end
  end

  assign base     = HUE_W'(HUE_SECTOR * sector);
  assign rem_full = hue_fold - base;

  assign split.sector = sector;
  assign split.rem    = rem_full[REM_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level: a four-stage pipeline with stall.
// Depends on hsv2rgb_pkg, hsv2rgb_hue_split and the assertion macro header.
`default_nettype none
`include "hsv_to_rgb_converter_defines.svh"

// Usage
// The input channel carries one request per accepted cycle: hue (1/256
// degree units), saturation and brightness (unsigned, 16 fraction bits,
// 65536 is 1.0). A request is taken at a rising edge where in_valid is high
// and in_stall is low. Results leave on red, green and blue under out_valid
// and out_stall with the same rule.
// Path: a request accepted into the stage one registers passes through the
// stage two and three registers to the output registers under out_valid.
// Throughput is one request per cycle while out_stall stays low, through the four register stages: hue
// split, reciprocal multiply for the sector fraction, the saturation
// products, and the brightness products with the channel select.
// Each stage moves forward whenever it is empty or its successor moves, so
// while out_stall holds a result, earlier bubbles are still filled and
// in_stall rises only once all four stages hold a request. Nothing is lost
// or repeated across a stall.
// Reset (rst, synchronous) clears the stage valid bits only; the block
// keeps no other state.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [HUE_W-1:0]   hue,
  input  wire logic [FIELD_W-1:0] saturation,
  input  wire logic [FIELD_W-1:0] brightness,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [FIELD_W-1:0] red,
  output      logic [FIELD_W-1:0] green,
  output      logic [FIELD_W-1:0] blue
);

  // Per-stage advance enables, computed back from the output.
  logic adv1, adv2, adv3, adv4;
  logic valid1, valid2, valid3;

  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !valid3 || adv4;
  assign adv2     = !valid2 || adv3;
  assign adv1     = !valid1 || adv2;
  assign in_stall = !adv1;

  // Stage 1: clamp the unit inputs and split the hue into sector and remainder.
  hue_split_t           split;
  logic [FIELD_W-1:0]   sat_clamp, bri_clamp;
  logic [SECTOR_W-1:0]  sector1;
  logic [REM_W-1:0]     rem1;
  logic [FIELD_W-1:0]   sat1, bri1;

  hsv2rgb_hue_split u_hue_split (
    .hue   (hue),
    .split (split)
  );

  assign sat_clamp = (saturation > ONE) ? ONE : saturation;
  assign bri_clamp = (brightness > ONE) ? ONE : brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv1) begin
      valid1 <= in_valid;
    end
    if (adv1) begin
      sector1 <= split.sector;
      rem1    <= split.rem;
      sat1    <= sat_clamp;
      bri1    <= bri_clamp;
    end
  end

  // Stage 2: sector fraction by multiplying with the reciprocal of a sector.
  logic [F_PROD_W-1:0]  f_prod;
  logic [SECTOR_W-1:0]  sector2;
  logic [FIELD_W-1:0]   frac2;
  logic [FIELD_W-1:0]   sat2, bri2;

  assign f_prod = F_PROD_W'(rem1) * F_PROD_W'(F_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv2) begin
      valid2 <= valid1;
    end
    if (adv2) begin
      sector2 <= sector1;
      frac2   <= FIELD_W'(f_prod[F_PROD_W-1:F_SHIFT]);
      sat2    <= sat1;
      bri2    <= bri1;
    end
  end

  // Stage 3: the three brightness scale factors 1-s, 1-s*f and 1-s*(1-f).
  logic [PROD_W-1:0]    sf_prod, sg_prod;
  logic [FIELD_W-1:0]   frac_inv;
  logic [SECTOR_W-1:0]  sector3;
  logic [FIELD_W-1:0]   kp3, kq3, kt3, bri3;

  assign frac_inv = ONE - frac2;
  assign sf_prod  = PROD_W'(sat2) * PROD_W'(frac2);
  assign sg_prod  = PROD_W'(sat2) * PROD_W'(frac_inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (adv3) begin
      valid3 <= valid2;
    end
    if (adv3) begin
      sector3 <= sector2;
      kp3     <= ONE - sat2;
      kq3     <= ONE - sf_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
      kt3     <= ONE - sg_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
      bri3    <= bri2;
    end
  end

  // Stage 4: p, q and t, then pick the channels by sector. Zero saturation
  // makes every factor one, so grey needs no path of its own.
  logic [PROD_W-1:0]  p_prod, q_prod, t_prod;
  logic [FIELD_W-1:0] p_val, q_val, t_val;
  logic [FIELD_W-1:0] red_next, green_next, blue_next;

  assign p_prod = PROD_W'(bri3) * PROD_W'(kp3);
  assign q_prod = PROD_W'(bri3) * PROD_W'(kq3);
  assign t_prod = PROD_W'(bri3) * PROD_W'(kt3);
  assign p_val  = p_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
  assign q_val  = q_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
  assign t_val  = t_prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];

  always_comb begin
    case (sector3)
      SEC_R_TO_Y: begin
        red_next = bri3;  green_next = t_val; blue_next = p_val;
      end
      SEC_Y_TO_G: begin
        red_next = q_val; green_next = bri3;  blue_next = p_val;
      end
      SEC_G_TO_C: begin
        red_next = p_val; green_next = bri3;  blue_next = t_val;
      end
      SEC_C_TO_B: begin
        red_next = p_val; green_next = q_val; blue_next = bri3;
      end
      SEC_B_TO_M: begin
        red_next = t_val; green_next = p_val; blue_next = bri3;
      end
      default: begin
        red_next = bri3;  green_next = p_val; blue_next = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv4) begin
      out_valid <= valid3;
    end
    if (adv4) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // Assertions.
  `HSV2RGB_ASSERT_NOW(a_frac_below_one, clk, rst, valid2, frac2 < ONE, "fraction reached one")
  `HSV2RGB_ASSERT_NOW(a_out_in_range, clk, rst, out_valid,
    (red <= ONE) && (green <= ONE) && (blue <= ONE), "output channel above one")
  `HSV2RGB_ASSERT_NEXT(a_stage1_holds, clk, rst, valid1 && !adv2,
    valid1 && $stable(sector1) && $stable(rem1), "stage one lost a held request")

endmodule

`default_nettype wire
